[rtl/batch_count_dispense_controller_core_macros.svh]
// ----------------------------------------------------------------------------
// Assertion macros for the batch dispenser core
// Shorthands for clocked implication checks with asynchronous reset disable.
// ----------------------------------------------------------------------------
`ifndef BATCH_COUNT_DISPENSE_CONTROLLER_CORE_MACROS_SVH
`define BATCH_COUNT_DISPENSE_CONTROLLER_CORE_MACROS_SVH

// same-cycle implication
`define BCD_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define BCD_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

[rtl/bcd_pkg.sv]
// ----------------------------------------------------------------------------
// bcd_pkg
// Shared types and constants of the batch dispenser core.
// ----------------------------------------------------------------------------
`default_nettype none

package bcd_pkg;

	localparam int COUNT_BITS_DEF = 16;

	localparam int TIMER_W    = 16;
	localparam int DROP_W     = 14;
	localparam int LEAD_W     = 5;
	localparam int TARGET_W   = 16;
	localparam int TOTAL_W    = 16;
	localparam int BLINK_W    = 3;
	localparam int STATUS_W   = 2;
	localparam int CODE_W     = 3;
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 16;
	localparam int IN_TDATA_W  = 24;
	localparam int OUT_TDATA_W = 48;

	localparam logic [TIMER_W-1:0] TIMER_MAX   = 16'hFFFF;
	localparam logic [TIMER_W-1:0] BLINK_TICKS = 16'd400;
	localparam logic [BLINK_W-1:0] BLINK_STEPS = 3'd6;

	localparam logic [DROP_W-1:0]  DROP_MIN = 14'd100;
	localparam logic [DROP_W-1:0]  DROP_MAX = 14'd10000;
	localparam logic [DROP_W-1:0]  DROP_RST = 14'd2000;
	localparam logic [TIMER_W-1:0] TMO_MIN  = 16'd500;
	localparam logic [TIMER_W-1:0] TMO_MAX  = 16'd60000;
	localparam logic [TIMER_W-1:0] TMO_RST  = 16'd5000;
	localparam logic [LEAD_W-1:0]  LEAD_MAX = 5'd30;
	localparam logic [LEAD_W-1:0]  LEAD_RST = 5'd1;

	// register indexes
	localparam logic [CFG_IDX_W-1:0] CFG_DROP_DELAY    = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_STAGE_TIMEOUT = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_LEAD          = 2'd2;

	// command status codes
	localparam logic [STATUS_W-1:0] ST_OK        = 2'd0;
	localparam logic [STATUS_W-1:0] ST_NO_TARGET = 2'd1;
	localparam logic [STATUS_W-1:0] ST_BUSY      = 2'd2;

	// phase codes as seen on the result stream
	localparam logic [CODE_W-1:0] CODE_IDLE   = 3'd0;
	localparam logic [CODE_W-1:0] CODE_FEED   = 3'd1;
	localparam logic [CODE_W-1:0] CODE_DROP   = 3'd2;
	localparam logic [CODE_W-1:0] CODE_VERIFY = 3'd3;
	localparam logic [CODE_W-1:0] CODE_BLINK  = 3'd4;
	localparam logic [CODE_W-1:0] CODE_DONE   = 3'd5;

	typedef enum logic [5:0] {
		PH_IDLE   = 6'b000001,
		PH_FEED   = 6'b000010,
		PH_DROP   = 6'b000100,
		PH_VERIFY = 6'b001000,
		PH_BLINK  = 6'b010000,
		PH_DONE   = 6'b100000
	} phase_t;

	typedef struct packed {
		logic [DROP_W-1:0]  drop_delay;
		logic [TIMER_W-1:0] stage_timeout;
		logic [LEAD_W-1:0]  early_close_lead;
	} cfg_t;

	typedef struct packed {
		logic                upper_pulse;
		logic                lower_pulse;
		logic                start_request;
		logic                stop_request;
		logic                load_target;
		logic [TARGET_W-1:0] target_value;
	} item_t;

	typedef struct packed {
		phase_t              phase;
		logic [TARGET_W-1:0] target;
		logic [TIMER_W-1:0]  phase_timer;
		logic [TIMER_W-1:0]  idle_timer;
		logic [BLINK_W-1:0]  blink_steps;
		logic                mismatch;
	} ctl_t;

	typedef struct packed {
		logic [STATUS_W-1:0] status;
		logic                feed_to;
		logic                ver_to;
		logic                done;
	} flags_t;

	function automatic logic [CODE_W-1:0] phase_code(input phase_t p);
		logic [CODE_W-1:0] c;
		case (p)
			PH_IDLE:   c = CODE_IDLE;
			PH_FEED:   c = CODE_FEED;
			PH_DROP:   c = CODE_DROP;
			PH_VERIFY: c = CODE_VERIFY;
			PH_BLINK:  c = CODE_BLINK;
			PH_DONE:   c = CODE_DONE;
			default:   c = CODE_IDLE;
		endcase
		return c;
	endfunction

endpackage

`default_nettype wire

[rtl/bcd_cfg.sv]
// ----------------------------------------------------------------------------
// bcd_cfg
// Configuration registers; out-of-range writes are dropped.
// ----------------------------------------------------------------------------
`default_nettype none

module bcd_cfg (
	input  wire logic                             clk,
	input  wire logic                             arst_n,
	input  wire logic                             wr_en,
	input  wire logic [bcd_pkg::CFG_IDX_W-1:0]    index,
	input  wire logic [bcd_pkg::CFG_DATA_W-1:0]   wdata,
	output bcd_pkg::cfg_t                         cfg
);

	bcd_pkg::cfg_t cfg_q;

	logic [bcd_pkg::DROP_W-1:0]  drop_v;
	logic [bcd_pkg::TIMER_W-1:0] tmo_v;
	logic [bcd_pkg::LEAD_W-1:0]  lead_v;

	assign drop_v = wdata[bcd_pkg::DROP_W-1:0];
	assign tmo_v  = wdata[bcd_pkg::TIMER_W-1:0];
	assign lead_v = wdata[bcd_pkg::LEAD_W-1:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.drop_delay       <= bcd_pkg::DROP_RST;
			cfg_q.stage_timeout    <= bcd_pkg::TMO_RST;
			cfg_q.early_close_lead <= bcd_pkg::LEAD_RST;
		end else if (wr_en) begin
			case (index)
				bcd_pkg::CFG_DROP_DELAY: begin
					if (drop_v >= bcd_pkg::DROP_MIN && drop_v <= bcd_pkg::DROP_MAX)
						cfg_q.drop_delay <= drop_v;
				end
				bcd_pkg::CFG_STAGE_TIMEOUT: begin
					if (tmo_v >= bcd_pkg::TMO_MIN && tmo_v <= bcd_pkg::TMO_MAX)
						cfg_q.stage_timeout <= tmo_v;
				end
				bcd_pkg::CFG_LEAD: begin
					if (lead_v <= bcd_pkg::LEAD_MAX)
						cfg_q.early_close_lead <= lead_v;
				end
				default: begin
				end
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

`default_nettype wire

[rtl/bcd_step.sv]
// ----------------------------------------------------------------------------
// bcd_step
// Next-state logic for one tick: timers, counts, commands, phase step.
// ----------------------------------------------------------------------------
`default_nettype none

module bcd_step #(
	parameter int COUNT_BITS = bcd_pkg::COUNT_BITS_DEF
) (
	input  wire bcd_pkg::cfg_t            cfg,
	input  wire bcd_pkg::item_t           item,
	input  wire bcd_pkg::ctl_t            ctl,
	input  wire logic [COUNT_BITS-1:0]    upper_cnt,
	input  wire logic [COUNT_BITS-1:0]    lower_cnt,
	output bcd_pkg::ctl_t                 ctl_nxt,
	output logic [COUNT_BITS-1:0]         upper_nxt,
	output logic [COUNT_BITS-1:0]         lower_nxt,
	output bcd_pkg::flags_t               flags
);

	localparam int CW = (COUNT_BITS > bcd_pkg::TARGET_W) ? COUNT_BITS : bcd_pkg::TARGET_W;
	localparam logic [COUNT_BITS-1:0] CNT_MAX = '1;

	logic [bcd_pkg::TIMER_W-1:0]  pt;
	logic [bcd_pkg::TIMER_W-1:0]  it;
	logic [bcd_pkg::TARGET_W-1:0] lead_ext;
	logic [bcd_pkg::TARGET_W-1:0] lim;
	logic [bcd_pkg::BLINK_W-1:0]  bs_inc;
	logic                         run;
	logic                         reached;

	always_comb begin
		pt = (ctl.phase_timer != bcd_pkg::TIMER_MAX) ?
			ctl.phase_timer + 16'd1 : bcd_pkg::TIMER_MAX;
		it = (ctl.idle_timer != bcd_pkg::TIMER_MAX) ?
			ctl.idle_timer + 16'd1 : bcd_pkg::TIMER_MAX;

		upper_nxt = upper_cnt;
		lower_nxt = lower_cnt;
		// a real upper count change restarts the no-progress timer
		if (item.upper_pulse && upper_cnt != CNT_MAX) begin
			upper_nxt = upper_cnt + COUNT_BITS'(1);
			it = '0;
		end
		if (item.lower_pulse && lower_cnt != CNT_MAX)
			lower_nxt = lower_cnt + COUNT_BITS'(1);

		ctl_nxt             = ctl;
		ctl_nxt.phase_timer = pt;
		ctl_nxt.idle_timer  = it;
		flags.status  = bcd_pkg::ST_OK;
		flags.feed_to = 1'b0;
		flags.ver_to  = 1'b0;
		flags.done    = 1'b0;
		run      = 1'b0;
		lead_ext = {{(bcd_pkg::TARGET_W-bcd_pkg::LEAD_W){1'b0}}, cfg.early_close_lead};
		lim      = 16'd1;
		reached  = 1'b0;
		bs_inc   = ctl.blink_steps + 3'd1;

		if (item.stop_request) begin
			ctl_nxt.phase       = bcd_pkg::PH_IDLE;
			ctl_nxt.target      = '0;
			ctl_nxt.phase_timer = '0;
			ctl_nxt.idle_timer  = '0;
			ctl_nxt.blink_steps = '0;
			ctl_nxt.mismatch    = 1'b0;
			upper_nxt = '0;
			lower_nxt = '0;
		end else begin
			if (item.load_target && item.target_value != '0)
				ctl_nxt.target = item.target_value;
			if (item.start_request) begin
				if (ctl_nxt.target == '0)
					flags.status = bcd_pkg::ST_NO_TARGET;
				else if (ctl.phase != bcd_pkg::PH_IDLE)
					flags.status = bcd_pkg::ST_BUSY;
				else
					run = 1'b1;
			end

			if (ctl_nxt.target > lead_ext)
				lim = ctl_nxt.target - lead_ext;
			reached = (lower_nxt >= upper_nxt);

			case (ctl.phase)
				bcd_pkg::PH_IDLE: begin
					if (run) begin
						upper_nxt = '0;
						lower_nxt = '0;
						ctl_nxt.mismatch    = 1'b0;
						ctl_nxt.phase_timer = '0;
						ctl_nxt.idle_timer  = '0;
						ctl_nxt.phase       = bcd_pkg::PH_FEED;
					end
				end
				bcd_pkg::PH_FEED: begin
					if (CW'(upper_nxt) >= CW'(lim)) begin
						ctl_nxt.phase_timer = '0;
						ctl_nxt.phase       = bcd_pkg::PH_DROP;
					end else if (it > cfg.stage_timeout) begin
						flags.feed_to       = 1'b1;
						ctl_nxt.phase_timer = '0;
						ctl_nxt.phase       = bcd_pkg::PH_DROP;
					end
				end
				bcd_pkg::PH_DROP: begin
					if (pt >= {2'b00, cfg.drop_delay}) begin
						ctl_nxt.phase_timer = '0;
						ctl_nxt.phase       = bcd_pkg::PH_VERIFY;
					end
				end
				bcd_pkg::PH_VERIFY: begin
					if (reached || pt > cfg.stage_timeout) begin
						flags.ver_to = !reached;
						if (lower_nxt != upper_nxt)
							ctl_nxt.mismatch = 1'b1;
						ctl_nxt.blink_steps = '0;
						ctl_nxt.phase_timer = '0;
						ctl_nxt.phase       = bcd_pkg::PH_BLINK;
					end
				end
				bcd_pkg::PH_BLINK: begin
					if (pt >= bcd_pkg::BLINK_TICKS) begin
						ctl_nxt.phase_timer = '0;
						ctl_nxt.blink_steps = bs_inc;
						if (bs_inc >= bcd_pkg::BLINK_STEPS)
							ctl_nxt.phase = bcd_pkg::PH_DONE;
					end
				end
				default: begin
					// done: clear the batch and report it
					upper_nxt = '0;
					lower_nxt = '0;
					ctl_nxt.target   = '0;
					ctl_nxt.mismatch = 1'b0;
					ctl_nxt.phase    = bcd_pkg::PH_IDLE;
					flags.done       = 1'b1;
				end
			endcase
		end
	end

endmodule

`default_nettype wire

[rtl/batch_count_dispense_controller_core.sv]
// ----------------------------------------------------------------------------
// batch_count_dispense_controller_core: two-gate batch dispenser, one tick/item
// An accepted tick request passes the input register, then its result
// is written to the result register.
// Throughput: one request per cycle unless stalled; one input-to-result stage.
// Reset (arst_n low, async): phase idle, counts/target/timers clear, defaults.
// ----------------------------------------------------------------------------
`default_nettype none

`include "batch_count_dispense_controller_core_macros.svh"

module batch_count_dispense_controller_core #(
	parameter int COUNT_BITS = bcd_pkg::COUNT_BITS_DEF
) (
	input  wire logic                               clk,
	input  wire logic                               arst_n,
	// tick requests
	input  wire logic                               s_axis_tvalid,
	output logic                                    s_axis_tready,
	// [0] upper_pulse, [1] lower_pulse, [2] start_request, [3] stop_request,
	// [4] load_target, [20:5] target_value, [23:21] zero
	input  wire logic [bcd_pkg::IN_TDATA_W-1:0]     s_axis_tdata,
	// results
	output logic                                    m_axis_tvalid,
	input  wire logic                               m_axis_tready,
	// [0] upper_gate_open, [1] lower_gate_open, [4:2] phase, [20:5] upper_total,
	// [36:21] lower_total, [37] count_mismatch, [38] blink_on,
	// [40:39] command_status, [41] feed_timed_out, [42] verify_timed_out,
	// [43] batch_done, [47:44] zero
	output logic [bcd_pkg::OUT_TDATA_W-1:0]         m_axis_tdata,
	// configuration writes
	input  wire logic                               cfg_wr_en,
	input  wire logic [bcd_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  wire logic [bcd_pkg::CFG_DATA_W-1:0]     cfg_wdata
);

	localparam int CW = (COUNT_BITS > bcd_pkg::TOTAL_W) ? COUNT_BITS : bcd_pkg::TOTAL_W;

	// ---------------------------------------------------------------
	// Configuration registers
	// ---------------------------------------------------------------
	bcd_pkg::cfg_t cfg;

	bcd_cfg u_cfg (
		.clk    (clk),
		.arst_n (arst_n),
		.wr_en  (cfg_wr_en),
		.index  (cfg_index),
		.wdata  (cfg_wdata),
		.cfg    (cfg)
	);

	// ---------------------------------------------------------------
	// Handshake. The input register (s1) holds one tick request; it moves
	// into the result register whenever that register is empty or being
	// drained, so a new request is taken every cycle while results flow.
	// ---------------------------------------------------------------
	logic             v_s1;
	bcd_pkg::item_t   item_s1;
	bcd_pkg::item_t   in_item;
	logic             out_valid_q;
	logic [bcd_pkg::OUT_TDATA_W-1:0] out_data_q;
	logic             adv;
	logic             take;

	assign adv           = !out_valid_q || m_axis_tready;
	assign take          = v_s1 && adv;
	assign s_axis_tready = !v_s1 || adv;

	assign in_item.upper_pulse   = s_axis_tdata[0];
	assign in_item.lower_pulse   = s_axis_tdata[1];
	assign in_item.start_request = s_axis_tdata[2];
	assign in_item.stop_request  = s_axis_tdata[3];
	assign in_item.load_target   = s_axis_tdata[4];
	assign in_item.target_value  = s_axis_tdata[20:5];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (s_axis_tready) begin
			v_s1 <= s_axis_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_axis_tvalid && s_axis_tready) begin
			item_s1 <= in_item;
		end
	end

	// ---------------------------------------------------------------
	// Controller state: phase, target, timers, blink counter, mismatch
	// flag and the two sensor counts. Updated once per tick request.
	// ---------------------------------------------------------------
	bcd_pkg::ctl_t           ctl_q;
	bcd_pkg::ctl_t           ctl_nxt;
	logic [COUNT_BITS-1:0]   upper_cnt_q;
	logic [COUNT_BITS-1:0]   lower_cnt_q;
	logic [COUNT_BITS-1:0]   upper_nxt;
	logic [COUNT_BITS-1:0]   lower_nxt;
	bcd_pkg::flags_t         flags;

	bcd_step #(
		.COUNT_BITS (COUNT_BITS)
	) u_step (
		.cfg       (cfg),
		.item      (item_s1),
		.ctl       (ctl_q),
		.upper_cnt (upper_cnt_q),
		.lower_cnt (lower_cnt_q),
		.ctl_nxt   (ctl_nxt),
		.upper_nxt (upper_nxt),
		.lower_nxt (lower_nxt),
		.flags     (flags)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_q.phase       <= bcd_pkg::PH_IDLE;
			ctl_q.target      <= '0;
			ctl_q.phase_timer <= '0;
			ctl_q.idle_timer  <= '0;
			ctl_q.blink_steps <= '0;
			ctl_q.mismatch    <= 1'b0;
			upper_cnt_q       <= '0;
			lower_cnt_q       <= '0;
		end else if (take) begin
			ctl_q       <= ctl_nxt;
			upper_cnt_q <= upper_nxt;
			lower_cnt_q <= lower_nxt;
		end
	end

	// ---------------------------------------------------------------
	// Result formatting from the state after the tick. Totals show the
	// low 16 bits of the counts (zero-extended for narrow counters).
	// ---------------------------------------------------------------
	logic [CW-1:0]                   upper_ext;
	logic [CW-1:0]                   lower_ext;
	logic                            blink_on;
	logic [bcd_pkg::OUT_TDATA_W-1:0] res_pack;

	assign upper_ext = CW'(upper_nxt);
	assign lower_ext = CW'(lower_nxt);
	assign blink_on  = (ctl_nxt.phase == bcd_pkg::PH_BLINK) && ctl_nxt.blink_steps[0];

	assign res_pack = {
		4'b0000,
		flags.done,
		flags.ver_to,
		flags.feed_to,
		flags.status,
		blink_on,
		ctl_nxt.mismatch,
		lower_ext[bcd_pkg::TOTAL_W-1:0],
		upper_ext[bcd_pkg::TOTAL_W-1:0],
		bcd_pkg::phase_code(ctl_nxt.phase),
		(ctl_nxt.phase == bcd_pkg::PH_VERIFY),
		(ctl_nxt.phase == bcd_pkg::PH_FEED)
	};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (adv) begin
			out_valid_q <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			out_data_q <= res_pack;
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = out_data_q;

	// ---------------------------------------------------------------
	// Checks
	// ---------------------------------------------------------------
	`BCD_ASSERT_IMP(a_stall_only_on_backpressure, clk, arst_n, !s_axis_tready, v_s1 && out_valid_q && !m_axis_tready, "input stalled without result backpressure")
	`BCD_ASSERT_NXT(a_stop_clears, clk, arst_n, take && item_s1.stop_request, ctl_q.phase == bcd_pkg::PH_IDLE && upper_cnt_q == '0 && lower_cnt_q == '0 && ctl_q.target == '0, "stop did not clear the batch")
	`BCD_ASSERT_NXT(a_done_returns_idle, clk, arst_n, take && !item_s1.stop_request && ctl_q.phase == bcd_pkg::PH_DONE, ctl_q.phase == bcd_pkg::PH_IDLE && out_data_q[43] && out_valid_q, "done phase did not finish the batch")
	`BCD_ASSERT_NXT(a_feed_entry_clean, clk, arst_n, take && !item_s1.stop_request && ctl_q.phase == bcd_pkg::PH_IDLE && ctl_nxt.phase == bcd_pkg::PH_FEED, upper_cnt_q == '0 && lower_cnt_q == '0 && !ctl_q.mismatch, "batch start left stale counts")

endmodule

`default_nettype wire

[tb/batch_count_dispense_controller_core_tb.sv]
// ----------------------------------------------------------------------------
// batch_count_dispense_controller_core_tb
// Self-checking bench for the two-gate batch dispenser. Tick requests go in
// on the slave stream, and a local copy of the controller predicts the
// status word of every tick. Each status word that comes out is checked
// field by field. The run covers command edge cases, register range
// handling, batches at several settings that run into feed and verify
// timeouts before a stop, and random batch traffic. Both streams idle at
// random.
// ----------------------------------------------------------------------------
`default_nettype none

module batch_count_dispense_controller_core_tb;
	timeunit 1ns;
	timeprecision 1ps;

	import bcd_pkg::*;

	localparam int CLK_HALF      = 5;
	localparam int IDLE_PCT      = 9;       // percent of cycles each side idles
	localparam int RANDOM_TICKS  = 350;
	localparam int DRAIN_CYCLES  = 8;
	localparam logic [TOTAL_W-1:0]   SENSOR_COUNT_MAX = '1;
	localparam logic [CFG_IDX_W-1:0] CFG_UNUSED       = 2'd3;

	// status word as packed on m_axis_tdata, MSB first
	typedef struct packed {
		logic [3:0]          pad;
		logic                batch_done;
		logic                verify_timed_out;
		logic                feed_timed_out;
		logic [STATUS_W-1:0] command_status;
		logic                blink_on;
		logic                count_mismatch;
		logic [TOTAL_W-1:0]  lower_total;
		logic [TOTAL_W-1:0]  upper_total;
		logic [CODE_W-1:0]   phase;
		logic                lower_gate_open;
		logic                upper_gate_open;
	} gate_report_t;

	logic                   clk = 1'b0;
	logic                   arst_n = 1'b0;
	logic                   s_axis_tvalid = 1'b0;
	logic                   s_axis_tready;
	logic [IN_TDATA_W-1:0]  s_axis_tdata = '0;
	logic                   m_axis_tvalid;
	logic                   m_axis_tready = 1'b0;
	logic [OUT_TDATA_W-1:0] m_axis_tdata;
	logic                   cfg_wr_en = 1'b0;
	logic [CFG_IDX_W-1:0]   cfg_index = CFG_DROP_DELAY;
	logic [CFG_DATA_W-1:0]  cfg_wdata = '0;

	// high while neither stream is allowed to idle
	logic steady_flow = 1'b0;

	// local copy of the controller: settings
	logic [DROP_W-1:0]  drop_ticks;
	logic [TIMER_W-1:0] stall_limit;
	logic [LEAD_W-1:0]  close_lead;
	// local copy of the controller: batch state
	logic [CODE_W-1:0]   cur_phase;
	logic [TOTAL_W-1:0]  upper_cnt;
	logic [TOTAL_W-1:0]  lower_cnt;
	logic [TARGET_W-1:0] batch_goal;
	logic [TIMER_W-1:0]  phase_ticks;
	logic [TIMER_W-1:0]  quiet_ticks;
	logic [BLINK_W-1:0]  blink_count;
	logic                mismatch_seen;

	// status words predicted for accepted tick requests, oldest first
	gate_report_t gate_reports[$];
	gate_report_t report_want;
	gate_report_t report_got;

	int ticks_sent      = 0;
	int results_checked = 0;
	int batches_done    = 0;
	int feed_timeouts   = 0;
	int verify_timeouts = 0;
	int refused_starts  = 0;
	int fail_count      = 0;

	batch_count_dispense_controller_core dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.cfg_wr_en     (cfg_wr_en),
		.cfg_index     (cfg_index),
		.cfg_wdata     (cfg_wdata)
	);

	always #CLK_HALF clk = ~clk;

	// ------------------------------------------------------------------
	// Controller prediction
	// ------------------------------------------------------------------

	// stop and reset share this: settings survive, the batch does not
	function automatic void clear_batch();
		cur_phase     = CODE_IDLE;
		upper_cnt     = '0;
		lower_cnt     = '0;
		batch_goal    = '0;
		phase_ticks   = '0;
		quiet_ticks   = '0;
		blink_count   = '0;
		mismatch_seen = 1'b0;
	endfunction

	// one millisecond tick: timers, then sensors, then commands, then phase
	function automatic void advance_dispenser(input logic up, lo, start, stop, load,
			input logic [TARGET_W-1:0] tval);
		gate_report_t r;
		logic run;
		logic reached;
		logic [TARGET_W-1:0] feed_limit;
		r = '0;
		run = 1'b0;
		if (phase_ticks != TIMER_MAX) phase_ticks = phase_ticks + 1'b1;
		if (quiet_ticks != TIMER_MAX) quiet_ticks = quiet_ticks + 1'b1;
		// a pulse on a pinned count is no progress and leaves the stall timer alone
		if (up && upper_cnt != SENSOR_COUNT_MAX) begin
			upper_cnt = upper_cnt + 1'b1;
			quiet_ticks = '0;
		end
		if (lo && lower_cnt != SENSOR_COUNT_MAX) lower_cnt = lower_cnt + 1'b1;

		if (stop) begin
			clear_batch();
		end else begin
			// load comes first so that a start in the same tick sees the new target
			if (load && tval != '0) batch_goal = tval;
			if (start) begin
				if (batch_goal == '0) r.command_status = ST_NO_TARGET;
				else if (cur_phase != CODE_IDLE) r.command_status = ST_BUSY;
				else run = 1'b1;
			end
			case (cur_phase)
				CODE_IDLE: if (run) begin
					// pulses of the start tick are dropped here
					upper_cnt = '0;
					lower_cnt = '0;
					mismatch_seen = 1'b0;
					phase_ticks = '0;
					quiet_ticks = '0;
					cur_phase = CODE_FEED;
				end
				CODE_FEED: begin
					feed_limit = (batch_goal > close_lead) ? batch_goal - close_lead : 1;
					if (upper_cnt >= feed_limit) begin
						phase_ticks = '0;
						cur_phase = CODE_DROP;
					end else if (quiet_ticks > stall_limit) begin
						r.feed_timed_out = 1'b1;
						phase_ticks = '0;
						cur_phase = CODE_DROP;
					end
				end
				CODE_DROP: if (phase_ticks >= drop_ticks) begin
					phase_ticks = '0;
					cur_phase = CODE_VERIFY;
				end
				CODE_VERIFY: begin
					reached = (lower_cnt >= upper_cnt);
					if (reached || phase_ticks > stall_limit) begin
						r.verify_timed_out = !reached;
						if (lower_cnt != upper_cnt) mismatch_seen = 1'b1;
						blink_count = '0;
						phase_ticks = '0;
						cur_phase = CODE_BLINK;
					end
				end
				CODE_BLINK: if (phase_ticks >= BLINK_TICKS) begin
					phase_ticks = '0;
					blink_count = blink_count + 1'b1;
					if (blink_count >= BLINK_STEPS) cur_phase = CODE_DONE;
				end
				default: begin
					// done shows for one tick, then the batch is wiped
					upper_cnt = '0;
					lower_cnt = '0;
					batch_goal = '0;
					mismatch_seen = 1'b0;
					cur_phase = CODE_IDLE;
					r.batch_done = 1'b1;
				end
			endcase
		end

		r.upper_gate_open = (cur_phase == CODE_FEED);
		r.lower_gate_open = (cur_phase == CODE_VERIFY);
		r.phase           = cur_phase;
		r.upper_total     = upper_cnt;
		r.lower_total     = lower_cnt;
		r.count_mismatch  = mismatch_seen;
		r.blink_on        = (cur_phase == CODE_BLINK) && blink_count[0];
		gate_reports.push_back(r);

		batches_done    += r.batch_done;
		feed_timeouts   += r.feed_timed_out;
		verify_timeouts += r.verify_timed_out;
		if (r.command_status != ST_OK) refused_starts++;
	endfunction

	// ------------------------------------------------------------------
	// Stream and register drivers
	// ------------------------------------------------------------------

	function automatic logic coin(input int pct);
		return ($urandom_range(99) < pct);
	endfunction

	// One tick request. tvalid stays up on return so back-to-back requests
	// never see it dropped and raised in one step; callers that pause call
	// settle(), which lowers it.
	task automatic send_tick(input logic up, lo, start, stop, load,
			input logic [TARGET_W-1:0] tval);
		logic taken;
		while (!steady_flow && coin(IDLE_PCT)) begin
			s_axis_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata  <= {3'b000, tval, load, stop, start, lo, up};
		// tready is sampled mid-cycle, where it holds its value for the next edge
		do begin
			@(negedge clk);
			taken = s_axis_tready;
			@(posedge clk);
		end while (!taken);
		ticks_sent++;
		advance_dispenser(up, lo, start, stop, load, tval);
	endtask

	task automatic send_noise();
		send_tick(coin(50), coin(50), coin(10), coin(4), coin(25),
			coin(50) ? 16'($urandom) : 16'($urandom_range(0, 40)));
	endtask

	// drain every outstanding status word before touching the registers
	task automatic settle();
		s_axis_tvalid <= 1'b0;
		while (gate_reports.size() != 0) @(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	// register write; out-of-range values are dropped by the controller
	task automatic write_setting(input logic [CFG_IDX_W-1:0] idx,
			input logic [CFG_DATA_W-1:0] value);
		@(posedge clk);
		cfg_wr_en <= 1'b1;
		cfg_index <= idx;
		cfg_wdata <= value;
		@(posedge clk);
		cfg_wr_en <= 1'b0;
		case (idx)
			CFG_DROP_DELAY: if (value[DROP_W-1:0] >= DROP_MIN &&
					value[DROP_W-1:0] <= DROP_MAX) begin
				drop_ticks = value[DROP_W-1:0];
			end
			CFG_STAGE_TIMEOUT: if (value >= TMO_MIN && value <= TMO_MAX) begin
				stall_limit = value;
			end
			CFG_LEAD: if (value[LEAD_W-1:0] <= LEAD_MAX) begin
				close_lead = value[LEAD_W-1:0];
			end
			default: ;
		endcase
	endtask

	// One batch as an operator would run it: load, start, feed the upper
	// sensor, let items fall through the lower one, with light noise on top.
	// Ends once the controller is idle again, or with a stop after stop_after
	// ticks.
	task automatic run_batch(input logic [TARGET_W-1:0] target, input int upper_goal,
			input int lower_goal, input int stop_after);
		int n;
		int ups;
		int los;
		logic up, lo, st, ld;
		logic [TARGET_W-1:0] tv;
		n = 0;
		ups = 0;
		los = 0;
		if (coin(50)) begin
			send_tick(coin(50), coin(50), 1'b1, 1'b0, 1'b1, target);
		end else begin
			send_tick(1'b0, 1'b0, 1'b0, 1'b0, 1'b1, target);
			send_tick(coin(50), coin(50), 1'b1, 1'b0, 1'b0, 16'($urandom));
		end
		while (cur_phase != CODE_IDLE && n < stop_after) begin
			up = 1'b0;
			lo = 1'b0;
			st = 1'b0;
			ld = 1'b0;
			tv = 16'($urandom);
			case (cur_phase)
				CODE_FEED: begin
					up = (ups < upper_goal) && coin(40);
					lo = coin(2);
					// a reload may only lower the limit, so the goal still closes the gate
					ld = coin(1);
					tv = 16'($urandom_range(0, target));
				end
				CODE_DROP, CODE_VERIFY: lo = (los < lower_goal) && coin(30);
				CODE_DONE: st = coin(50);
				default: begin
					up = coin(1);
					lo = coin(1);
				end
			endcase
			if (coin(1)) st = 1'b1;
			send_tick(up, lo, st, 1'b0, ld, tv);
			ups += up;
			los += lo;
			n++;
		end
		if (cur_phase != CODE_IDLE) send_tick(coin(50), coin(50), coin(50), 1'b1, coin(50),
			16'($urandom));
	endtask

	// ------------------------------------------------------------------
	// Result side: random stalls and the field-by-field check
	// ------------------------------------------------------------------

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) m_axis_tready <= 1'b0;
		else m_axis_tready <= steady_flow || !coin(IDLE_PCT);
	end

	function automatic void check_field(input string name, input logic [15:0] want, got);
		if (got !== want) begin
			$error("%s: expected %0d, got %0d", name, want, got);
			fail_count++;
		end
	endfunction

	// checked mid-cycle; the transfer itself completes at the next edge
	always @(negedge clk) begin
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			report_got = m_axis_tdata;
			if (gate_reports.size() == 0) begin
				$error("status word with no tick request pending: %h", m_axis_tdata);
				fail_count++;
			end else begin
				report_want = gate_reports.pop_front();
				results_checked++;
				check_field("upper_gate_open", report_want.upper_gate_open,
					report_got.upper_gate_open);
				check_field("lower_gate_open", report_want.lower_gate_open,
					report_got.lower_gate_open);
				check_field("phase", report_want.phase, report_got.phase);
				check_field("upper_total", report_want.upper_total, report_got.upper_total);
				check_field("lower_total", report_want.lower_total, report_got.lower_total);
				check_field("count_mismatch", report_want.count_mismatch,
					report_got.count_mismatch);
				check_field("blink_on", report_want.blink_on, report_got.blink_on);
				check_field("command_status", report_want.command_status,
					report_got.command_status);
				check_field("feed_timed_out", report_want.feed_timed_out,
					report_got.feed_timed_out);
				check_field("verify_timed_out", report_want.verify_timed_out,
					report_got.verify_timed_out);
				check_field("batch_done", report_want.batch_done, report_got.batch_done);
				check_field("pad", report_want.pad, report_got.pad);
			end
		end
	end

	// ------------------------------------------------------------------
	// Tests
	// ------------------------------------------------------------------

	// command handling at reset settings (drop 2000, timeout 5000, lead 1)
	task automatic test_commands();
		send_tick(1'b0, 1'b0, 1'b1, 1'b0, 1'b0, 16'h0000);   // start, no target
		send_tick(1'b0, 1'b0, 1'b0, 1'b0, 1'b1, 16'h0000);   // zero load is dropped
		send_tick(1'b0, 1'b0, 1'b1, 1'b0, 1'b0, 16'hFFFF);   // value without load
		send_tick(1'b1, 1'b0, 1'b0, 1'b0, 1'b0, 16'h0000);   // sensors count when idle
		send_tick(1'b0, 1'b1, 1'b0, 1'b0, 1'b0, 16'h0000);
		send_tick(1'b0, 1'b0, 1'b0, 1'b0, 1'b1, 16'hFFFF);   // largest target
		send_tick(1'b0, 1'b0, 1'b0, 1'b0, 1'b1, 16'd3);      // replaced
		send_tick(1'b1, 1'b1, 1'b1, 1'b0, 1'b1, 16'd2);      // load+start, pulses lost
		send_tick(1'b0, 1'b0, 1'b1, 1'b0, 1'b0, 16'h0000);   // start while feeding
		send_tick(1'b1, 1'b0, 1'b0, 1'b0, 1'b1, 16'd5);      // limit rises to 4
		send_tick(1'b0, 1'b0, 1'b0, 1'b0, 1'b1, 16'd1);      // limit 1: gate closes
		send_tick(1'b0, 1'b1, 1'b1, 1'b0, 1'b0, 16'h0000);   // start in drop wait
		send_tick(1'b1, 1'b1, 1'b1, 1'b1, 1'b1, 16'hFFFF);   // stop beats everything
		send_tick(1'b0, 1'b0, 1'b1, 1'b0, 1'b0, 16'h0000);   // target gone after stop
		send_tick(1'b0, 1'b0, 1'b0, 1'b1, 1'b0, 16'h0000);   // stop while idle
	endtask

	// Range checks on every register: each rejected write follows a good one,
	// and the batch after it runs on the values that must have stuck.
	task automatic test_setting_limits();
		settle();
		write_setting(CFG_STAGE_TIMEOUT, 16'd500);
		write_setting(CFG_STAGE_TIMEOUT, 16'd499);
		write_setting(CFG_STAGE_TIMEOUT, 16'd60001);
		write_setting(CFG_STAGE_TIMEOUT, 16'hFFFF);
		write_setting(CFG_DROP_DELAY, 16'hC064);     // upper bits ignored: 100
		write_setting(CFG_DROP_DELAY, 16'd99);
		write_setting(CFG_DROP_DELAY, 16'd10001);
		write_setting(CFG_DROP_DELAY, 16'h3FFF);
		write_setting(CFG_LEAD, 16'hFFE0);           // upper bits ignored: 0
		write_setting(CFG_LEAD, 16'd31);
		write_setting(CFG_LEAD, 16'hFFFF);
		write_setting(CFG_UNUSED, 16'hFFFF);
		// short feed that times out, extra items at the lower sensor; the stop
		// lands shortly after the drop wait
		run_batch(16'd8, 3, 5, 650);
	endtask

	task automatic test_full_batches();
		// feed closes early, verify gives up on missing items, stop during blink
		settle();
		write_setting(CFG_DROP_DELAY, 16'd100);
		write_setting(CFG_STAGE_TIMEOUT, 16'd500);
		write_setting(CFG_LEAD, 16'd3);
		run_batch(16'd9, 9, 2, 660);

		// all registers at their top values, no idling anywhere, stop in drop wait
		settle();
		write_setting(CFG_DROP_DELAY, 16'(DROP_MAX));
		write_setting(CFG_STAGE_TIMEOUT, TMO_MAX);
		write_setting(CFG_LEAD, 16'(LEAD_MAX));
		steady_flow = 1'b1;
		run_batch(16'd25, 1, 1, 150);
		steady_flow = 1'b0;
	endtask

	// mostly well-formed batches cut short by a stop, mixed with noise bursts
	task automatic test_random_traffic();
		int first;
		int episodes;
		settle();
		write_setting(CFG_DROP_DELAY, 16'($urandom_range(100, 160)));
		write_setting(CFG_STAGE_TIMEOUT, 16'($urandom_range(500, 540)));
		write_setting(CFG_LEAD, 16'($urandom_range(0, 4)));
		first = ticks_sent;
		episodes = 0;
		while (ticks_sent - first < RANDOM_TICKS) begin
			episodes++;
			if (episodes % 7 == 0 && cur_phase == CODE_IDLE) begin
				// new lead between batches; 31 must be rejected
				settle();
				write_setting(CFG_LEAD, 16'($urandom_range(0, 31)));
			end
			if (coin(80)) begin
				run_batch(16'($urandom_range(1, 40)), $urandom_range(0, 45),
					$urandom_range(0, 45),
					coin(70) ? $urandom_range(3, 60) : $urandom_range(100, 200));
			end else begin
				repeat ($urandom_range(1, 12)) send_noise();
			end
		end
	endtask

	// ------------------------------------------------------------------
	// Sequence
	// ------------------------------------------------------------------

	initial begin
		clear_batch();
		drop_ticks  = DROP_RST;
		stall_limit = TMO_RST;
		close_lead  = LEAD_RST;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_commands();
		test_setting_limits();
		test_full_batches();
		test_random_traffic();

		// let the last status words come out, then watch for strays
		s_axis_tvalid <= 1'b0;
		while (gate_reports.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		$display("Ran %0d tick requests, %0d status words checked: commands, register limits,",
			ticks_sent, results_checked);
		$display("batches cut short by stops, %0d whole batches (%0d feed / %0d verify timeouts), %0d refused starts",
			batches_done, feed_timeouts, verify_timeouts, refused_starts);
		if (fail_count == 0) begin
			$display("batch_count_dispense_controller_core regression: pass");
		end else begin
			$display("batch_count_dispense_controller_core regression: fail");
		end
		$finish;
	end

	// hang guard
	initial begin
		#12_000_000;
		$display("batch_count_dispense_controller_core regression: fail");
		$finish;
	end

endmodule

`default_nettype wire
